[design/cvc_pkg.sv]
// Shared types and constants of the capsule voxel collision unit.
`default_nettype none
package cvc_pkg;

  localparam int CHUNK_SIZE_DEF = 32;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int NORM_ONE       = 16384;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_FLAG  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]   operation;
    logic [4:0]   voxel_x;
    logic [4:0]   voxel_y;
    logic [4:0]   voxel_z;
    logic [7:0]   block_type;
    logic         decorative;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic signed [15:0] center_z;
    logic [10:0]  radius;
    logic [11:0]  capsule_height;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
  } out_item_t;

  // Request to the normal unit.
  typedef struct packed {
    logic               start;
    logic signed [19:0] px;
    logic signed [19:0] py;
    logic signed [19:0] pz;
    logic [39:0]        dsq;
  } norm_req_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
  } norm_rsp_t;

endpackage
`default_nettype wire

[design/cvc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module cvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[design/cvc_norm.sv]
// Normal unit: bit-serial square root, then three bit-serial divisions.
`default_nettype none
module cvc_norm (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cvc_pkg::norm_req_t req,
  output cvc_pkg::norm_rsp_t      rsp
);
  import cvc_pkg::*;

  typedef enum logic [3:0] {
    N_IDLE = 4'b0001,
    N_SQRT = 4'b0010,
    N_DIV  = 4'b0100,
    N_DONE = 4'b1000
  } nst_t;

  nst_t state_r, state_nxt;
  // Root of dsq * 2^32: radicand 72 bits, root 36 bits.
  logic [71:0] rad_r, rad_nxt;
  logic [37:0] rem_r, rem_nxt;
  logic [35:0] root_r, root_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [1:0]  comp_r, comp_nxt;
  // Division of mag*2^30 + d/2 by d; quotient kept up to 15 bits plus overflow.
  logic [50:0] dnum_r, dnum_nxt;
  logic [36:0] drem_r, drem_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic signed [19:0] p_r [3];
  logic signed [15:0] n_r [3];
  logic signed [15:0] n_nxt [3];

  logic [37:0] trial;
  logic [36:0] dshift;
  logic [19:0] mag;
  logic [50:0] numer;
  logic [15:0] qclamp;

  always_comb begin
    state_nxt = state_r;
    rad_nxt   = rad_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    cnt_nxt   = cnt_r;
    comp_nxt  = comp_r;
    dnum_nxt  = dnum_r;
    drem_nxt  = drem_r;
    quo_nxt   = quo_r;
    n_nxt     = n_r;
    trial     = '0;
    dshift    = '0;
    mag       = p_r[comp_r] < 0 ? 20'(-p_r[comp_r]) : 20'(p_r[comp_r]);
    numer     = {mag, 30'd0} + 51'(root_r[35:1]);
    qclamp    = '0;
    case (state_r)
      N_IDLE: begin
        if (req.start) begin
          rad_nxt   = {req.dsq[39:0], 32'd0};
          rem_nxt   = '0;
          root_nxt  = '0;
          cnt_nxt   = 6'd36;
          state_nxt = N_SQRT;
        end
      end
      N_SQRT: begin
        rem_nxt = {rem_r[35:0], rad_r[71:70]};
        trial   = {root_r, 2'b01};
        rad_nxt = {rad_r[69:0], 2'b00};
        if (rem_nxt >= trial) begin
          rem_nxt  = rem_nxt - trial;
          root_nxt = {root_r[34:0], 1'b1};
        end else begin
          root_nxt = {root_r[34:0], 1'b0};
        end
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          comp_nxt  = 2'd0;
          cnt_nxt   = 6'd51;
          drem_nxt  = '0;
          quo_nxt   = '0;
          state_nxt = N_DIV;
        end
      end
      N_DIV: begin
        if (cnt_r == 6'd51) begin
          dnum_nxt = numer;
          drem_nxt = '0;
          quo_nxt  = '0;
          cnt_nxt  = 6'd50;
        end else begin
          dshift   = {drem_r[35:0], dnum_r[50]};
          dnum_nxt = {dnum_r[49:0], 1'b0};
          if (dshift >= {1'b0, root_r}) begin
            drem_nxt = dshift - {1'b0, root_r};
            quo_nxt  = (quo_r[15] ? quo_r : {quo_r[14:0], 1'b1});
          end else begin
            drem_nxt = dshift;
            quo_nxt  = (quo_r[15] ? quo_r : {quo_r[14:0], 1'b0});
          end
          // Saturate once the quotient already exceeds the clamp bound.
          if (quo_r > 16'(NORM_ONE)) quo_nxt = 16'h8000;
          if (cnt_r == 6'd0) begin
            // The last quotient bit is the one just formed above.
            qclamp = quo_nxt > 16'(NORM_ONE) ? 16'(NORM_ONE) : quo_nxt;
            n_nxt[comp_r] = p_r[comp_r] < 0 ? -$signed(qclamp) : $signed(qclamp);
            cnt_nxt = 6'd51;
            if (comp_r == 2'd2) state_nxt = N_DONE;
            else comp_nxt = comp_r + 2'd1;
          end else begin
            cnt_nxt = cnt_r - 6'd1;
          end
        end
      end
      N_DONE: state_nxt = N_IDLE;
      default: state_nxt = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= N_IDLE;
    else state_r <= state_nxt;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
    comp_r <= comp_nxt;
    dnum_r <= dnum_nxt;
    drem_r <= drem_nxt;
    quo_r  <= quo_nxt;
    n_r    <= n_nxt;
    if (state_r == N_IDLE && req.start) begin
      p_r[0] <= req.px;
      p_r[1] <= req.py;
      p_r[2] <= req.pz;
    end
  end

  assign rsp = '{done: state_r == N_DONE, nx: n_r[0], ny: n_r[1], nz: n_r[2]};

`ifndef NO_ASSERTIONS
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |=> !rsp.done) else $error("normal done held");
  a_cnt_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == N_SQRT |-> cnt_r != 6'd0) else $error("sqrt count underflow");
  a_comp: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == N_DIV |-> comp_r != 2'd3) else $error("bad component");
`endif
endmodule
`default_nettype wire

[design/capsule_voxel_collision_unit.sv]
// Top level of the capsule voxel collision unit: scan sequencer and stores.
//
// Each transfer on the input side produces exactly one result strobe, and the
// receiver cannot stall it. Voxel writes and flag sets are made in S_BOX.
// A query first computes the clamped bounding box, then walks it with x
// outermost and z innermost, one voxel per cycle through the voxel RAM and
// then through the flag RAM (registered read path, pipelined). The first hit
// with a nonzero distance runs the normal unit: a square root and then a
// division per axis. A zero-distance hit takes the dominant-axis normal at
// once. After reset a clearing pass writes air to all CHUNK_SIZE^3 voxels and
// zero to all 256 flags, one entry per cycle, while busy stays high.
`default_nettype none
module capsule_voxel_collision_unit #(
  parameter int CHUNK_SIZE = cvc_pkg::CHUNK_SIZE_DEF,
  parameter int FRAC_BITS  = cvc_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire cvc_pkg::in_item_t  in_item,
  output logic                    out_valid,
  output cvc_pkg::out_item_t      out_item
);
  import cvc_pkg::*;

  localparam int CB    = $clog2(CHUNK_SIZE);
  localparam int AB    = 3 * CB;
  localparam int DEPTH = 1 << AB;
  localparam int CLR_N = DEPTH > 256 ? DEPTH : 256;
  localparam int CW    = $clog2(CLR_N) + 1;
  localparam int SH    = FRAC_BITS + 1;          // shift for voxel size S
  // Geometry width in half-LSB units: the chunk extent plus sign and margin.
  localparam int GW    = (CB + SH + 2 > 20) ? CB + SH + 2 : 20;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_BOX   = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_NORM  = 7'b0010000,
    S_DRAIN = 7'b0100000,
    S_RESP  = 7'b1000000
  } st_t;

  st_t state_r, state_nxt;
  in_item_t item_r;
  logic [CW-1:0] clr_r;

  logic signed [GW-1:0] cx_r, cy_r, cz_r, r_r, h_r, chh_r;
  logic [CB-1:0] x0_r, x1_r, y0_r, y1_r, z0_r, z1_r;
  logic [CB-1:0] sx_r, sy_r, sz_r;
  logic          sdone_r;
  // Read pipeline: stage 1 voxel data, stage 2 flag data.
  logic          v1_r, v2_r;
  logic [CB-1:0] p1x_r, p1y_r, p1z_r, p2x_r, p2y_r, p2z_r;
  logic [7:0]    t2_r;
  logic signed [GW-1:0] ay2_r;
  logic          hit_r;
  logic signed [15:0] nx_r, ny_r, nz_r;

  // RAM ports.
  logic          vwe, fwe;
  logic [AB-1:0] vwa, vra;
  logic [7:0]    vwd, vrd, fwa, fra;
  logic          fwd, frd;

  cvc_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_vox (
    .clk(clk), .we(vwe), .waddr(vwa), .wdata(vwd), .raddr(vra), .rdata(vrd));
  cvc_ram #(.WIDTH(1), .DEPTH(256)) u_flag (
    .clk(clk), .we(fwe), .waddr(fwa), .wdata(fwd), .raddr(fra), .rdata(frd));

  norm_req_t nreq;
  norm_rsp_t nrsp;
  cvc_norm u_norm (.clk(clk), .rst_n(rst_n), .req(nreq), .rsp(nrsp));

  // Box bounds: floor/ceil divide by S is an arithmetic shift.
  function automatic logic [CB-1:0] clampi(input logic signed [GW-1:0] v);
    if (v < 0) return '0;
    if (v > GW'(CHUNK_SIZE - 1)) return CB'(CHUNK_SIZE - 1);
    return v[CB-1:0];
  endfunction
  function automatic logic signed [GW-1:0] cdiv(input logic signed [GW-1:0] v);
    return (v + GW'((1 << SH) - 1)) >>> SH;
  endfunction
  function automatic logic signed [GW-1:0] clr3(input logic signed [GW-1:0] v,
      input logic signed [GW-1:0] lo, input logic signed [GW-1:0] hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // The axis point is chosen in stage 1; the voxel test runs in stage 2.
  logic signed [GW-1:0] vx, vy, vz, vy1, yoff, ay, px, py, pz, dx, dy, dz;
  logic signed [GW-1:0] adx, ady, adz;
  logic [39:0] dsq, rsq;
  logic        solid, touch;
  logic signed [15:0] zx, zy, zz;

  always_comb begin
    vy1  = GW'(p1y_r) <<< SH;
    yoff = vy1 + GW'(1 << FRAC_BITS) - cy_r;
    if (yoff > chh_r) ay = cy_r + chh_r;
    else if (yoff < -chh_r) ay = cy_r - chh_r;
    else ay = cy_r + yoff;
    vx   = GW'(p2x_r) <<< SH;
    vy   = GW'(p2y_r) <<< SH;
    vz   = GW'(p2z_r) <<< SH;
    px = cx_r - clr3(cx_r, vx, vx + GW'(1 << SH));
    py = ay2_r - clr3(ay2_r, vy, vy + GW'(1 << SH));
    pz = cz_r - clr3(cz_r, vz, vz + GW'(1 << SH));
    dsq = 40'(px * px) + 40'(py * py) + 40'(pz * pz);
    rsq = 40'(r_r * r_r);
    solid = v2_r && t2_r != 8'd0 && !frd;
    touch = solid && dsq <= rsq;
    dx = cx_r - (vx + GW'(1 << FRAC_BITS));
    dy = ay2_r - (vy + GW'(1 << FRAC_BITS));
    dz = cz_r - (vz + GW'(1 << FRAC_BITS));
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    adz = dz < 0 ? -dz : dz;
    zx = '0; zy = '0; zz = '0;
    if (adx > ady && adx > adz) zx = dx > 0 ? 16'(NORM_ONE) : -16'(NORM_ONE);
    else if (ady > adz) zy = dy > 0 ? 16'(NORM_ONE) : -16'(NORM_ONE);
    else zz = dz > 0 ? 16'(NORM_ONE) : -16'(NORM_ONE);
  end

  assign nreq = '{start: state_r == S_SCAN && touch && dsq != 0,
                  px: 20'(px), py: 20'(py), pz: 20'(pz), dsq: dsq};

  logic in_ok;
  assign in_ok = 32'(item_r.voxel_x) < CHUNK_SIZE && 32'(item_r.voxel_y) < CHUNK_SIZE
              && 32'(item_r.voxel_z) < CHUNK_SIZE;

  always_comb begin
    vwe = 1'b0; vwa = clr_r[AB-1:0]; vwd = '0;
    fwe = 1'b0; fwa = clr_r[7:0];    fwd = 1'b0;
    vra = {sx_r, sy_r, sz_r};
    fra = vrd;
    if (state_r == S_CLEAR) begin
      vwe = clr_r < CW'(DEPTH);
      fwe = clr_r <= CW'(255);
    end else if (state_r == S_BOX && item_r.operation == OP_WRITE && in_ok) begin
      vwe = 1'b1;
      vwa = {CB'(item_r.voxel_x), CB'(item_r.voxel_y), CB'(item_r.voxel_z)};
      vwd = item_r.block_type;
    end else if (state_r == S_BOX && item_r.operation == OP_FLAG) begin
      fwe = 1'b1;
      fwa = item_r.block_type;
      fwd = item_r.decorative;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == CW'(CLR_N - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (start) state_nxt = S_BOX;
      S_BOX:   state_nxt = item_r.operation == OP_QUERY ? S_SCAN : S_RESP;
      S_SCAN: begin
        if (touch) state_nxt = dsq != 0 ? S_NORM : S_RESP;
        else if (sdone_r && !v1_r && !v2_r) state_nxt = S_RESP;
      end
      S_NORM:  if (nrsp.done) state_nxt = S_RESP;
      S_DRAIN: state_nxt = S_RESP;
      S_RESP:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // The clamped box always holds at least one voxel, even for a capsule
  // that lies beyond the chunk.
  logic signed [GW-1:0] bcx, bcy, bcz, br, bh;
  always_comb begin
    bcx = GW'(item_r.center_x) <<< 1;
    bcy = GW'(item_r.center_y) <<< 1;
    bcz = GW'(item_r.center_z) <<< 1;
    br  = GW'({item_r.radius, 1'b0});
    bh  = GW'(item_r.capsule_height);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      sdone_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      v1_r <= state_r == S_SCAN && !sdone_r && !touch;
      v2_r <= v1_r && state_r == S_SCAN && !touch;
      if (state_r == S_BOX) sdone_r <= item_r.operation != OP_QUERY;
      else if (state_r == S_SCAN && !sdone_r && !touch)
        sdone_r <= sx_r == x1_r && sy_r == y1_r && sz_r == z1_r;
    end
    if (state_r == S_IDLE && start) item_r <= in_item;
    p1x_r <= sx_r; p1y_r <= sy_r; p1z_r <= sz_r;
    p2x_r <= p1x_r; p2y_r <= p1y_r; p2z_r <= p1z_r;
    ay2_r <= ay;
    t2_r  <= vrd;
    if (state_r == S_BOX) begin
      cx_r <= bcx; cy_r <= bcy; cz_r <= bcz; r_r <= br; h_r <= bh;
      chh_r <= bh - br;
      x0_r <= clampi((bcx - br) >>> SH); x1_r <= clampi(cdiv(bcx + br));
      y0_r <= clampi((bcy - bh) >>> SH); y1_r <= clampi(cdiv(bcy + bh));
      z0_r <= clampi((bcz - br) >>> SH); z1_r <= clampi(cdiv(bcz + br));
      sx_r <= clampi((bcx - br) >>> SH);
      sy_r <= clampi((bcy - bh) >>> SH);
      sz_r <= clampi((bcz - br) >>> SH);
      hit_r <= 1'b0; nx_r <= '0; ny_r <= '0; nz_r <= '0;
    end else if (state_r == S_SCAN) begin
      if (touch) begin
        hit_r <= 1'b1;
        nx_r <= zx; ny_r <= zy; nz_r <= zz;
      end else if (!sdone_r) begin
        if (sz_r != z1_r) sz_r <= sz_r + 1'b1;
        else begin
          sz_r <= z0_r;
          if (sy_r != y1_r) sy_r <= sy_r + 1'b1;
          else begin
            sy_r <= y0_r;
            sx_r <= sx_r + 1'b1;
          end
        end
      end
    end else if (state_r == S_NORM && nrsp.done) begin
      nx_r <= nrsp.nx; ny_r <= nrsp.ny; nz_r <= nrsp.nz;
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = state_r == S_RESP;
  assign out_item  = '{hit: hit_r, normal_x: nx_r, normal_y: ny_r, normal_z: nz_r};

`ifndef NO_ASSERTIONS
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");
  a_busy_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result without busy");
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("transfer not taken");
  a_hit_q: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.hit |-> item_r.operation == OP_QUERY)
    else $error("hit on non-query");
`endif
endmodule
`default_nettype wire
